// ===== rtl/pcmcv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcmcv_pkg
// shared types, register indexes, format codes and sample constants for the
// pcm frame to stereo s16 converter
// ----------------------------------------------------------------------------
package pcmcv_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_VOL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 2'd2;

  // register widths and reset values
  localparam int FMT_W   = 3;
  localparam int VOL_W   = 16;
  localparam int MGAIN_W = 17;

  localparam logic [FMT_W-1:0] FMT_S16_MONO    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16_STEREO  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S16_8CH     = 3'd2;
  localparam logic [FMT_W-1:0] FMT_F32_MONO    = 3'd3;
  localparam logic [FMT_W-1:0] FMT_F32_STEREO  = 3'd4;
  localparam logic [FMT_W-1:0] FMT_F32_8CH     = 3'd5;
  localparam logic [FMT_W-1:0] FMT_S16_8CH_ALT = 3'd6;
  localparam logic [FMT_W-1:0] FMT_F32_8CH_ALT = 3'd7;

  localparam logic [FMT_W-1:0]   FMT_RST   = FMT_S16_STEREO;
  localparam logic [VOL_W-1:0]   VOL_RST   = 16'd32768;
  localparam logic [MGAIN_W-1:0] MGAIN_RST = 17'd32768;

  // sample words
  localparam int SAMPLE_W = 32;
  localparam int PCM_W    = 16;
  localparam int MAG_W    = 15;  // full scale is 2^15 - 1

  localparam int              S16_FRAC_BITS    = 15;
  localparam int              F32_SHIFT_BASE   = 150;  // bias 127 plus 23 mantissa bits
  localparam logic [7:0]      F32_EXP_SPECIAL  = 8'hFF;
  localparam logic [MAG_W-1:0] PCM_FULL_SCALE  = 15'h7FFF;

  // final shift is capped here, anything larger already yields zero
  localparam int SHIFT_W   = 6;
  localparam int SHIFT_MAX = 63;

  // pipeline advance strobes from the top level to the lanes
  typedef struct packed {
    logic ld_s1;   // product stage takes a new word
    logic ld_out;  // output stage takes the product stage
  } pcmcv_adv_t;

  function automatic logic fmt_is_mono(input logic [FMT_W-1:0] fmt);
    logic mono;
    unique case (fmt)
      FMT_S16_MONO, FMT_F32_MONO: mono = 1'b1;
      default:                    mono = 1'b0;
    endcase
    return mono;
  endfunction

  function automatic logic fmt_float32(input logic [FMT_W-1:0] fmt);
    logic flt;
    unique case (fmt)
      FMT_F32_MONO, FMT_F32_STEREO, FMT_F32_8CH, FMT_F32_8CH_ALT: flt = 1'b1;
      default:                                                    flt = 1'b0;
    endcase
    return flt;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pcm_frame_to_stereo_s16_gain_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_frame_to_stereo_s16_gain_unit
// audio frame to stereo s16 converter with combined port and master gain
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per frame, the raw bits of the first two sample
//   words plus the buffer end flag, taken when in_valid_i is high and
//   in_stall_o low. output channel: left and right s16 samples and the
//   copied buffer end flag, taken when out_valid_o is high and out_stall_i low
//   config: plain write port, index 0 format, 1 port volume, 2 master gain;
//   write only while no word is in flight. the combined gain is worked out
//   from the write data and registered at the write edge, so every word
//   taken after that edge uses the new setting
//   path: an accepted word passes the product register, then the output register
//   throughput: one word per cycle without stalls, two stage pipeline per side
//   stall: out_stall_i holds the output word; the product stage still drains
//   into an empty output and a new word is taken unless both stages are full
//   reset: pipeline empty, format stereo s16, volume and master gain at unity
// ----------------------------------------------------------------------------
module pcm_frame_to_stereo_s16_gain_unit
  import pcmcv_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input word
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SAMPLE_W-1:0]   first_sample_i,
  input  wire logic [SAMPLE_W-1:0]   second_sample_i,
  input  wire logic                  buffer_end_i,
  // output word
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [PCM_W-1:0]    left_pcm_o,
  output logic signed [PCM_W-1:0]    right_pcm_o,
  output logic                       buffer_end_out_o
);

  localparam int GAIN_W = GAIN_FRAC_BITS + 2;

  logic [FMT_W-1:0]  format;
  logic [GAIN_W-1:0] gain;
  logic              mono, float_fmt;
  logic [SAMPLE_W-1:0] right_raw;

  // config registers and combined gain
  pcmcv_gain #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_gain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .format_o   (format),
    .gain_o     (gain)
  );

  assign mono      = fmt_is_mono(format);
  assign float_fmt = fmt_float32(format);
  // mono copies sample 0 to both sides
  assign right_raw = mono ? first_sample_i : second_sample_i;

  // pipeline control
  logic       s1_vld_q, s1_vld_d;
  logic       out_vld_q, out_vld_d;
  logic       be_s1_q, be_out_q;
  logic       out_free, s1_free;
  pcmcv_adv_t adv;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_free    = !s1_vld_q || out_free;
  assign in_stall_o = !s1_free;

  assign adv.ld_s1  = s1_free && in_valid_i;
  assign adv.ld_out = out_free && s1_vld_q;

  always_comb begin
    s1_vld_d  = s1_free ? in_valid_i : s1_vld_q;
    out_vld_d = out_free ? s1_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // buffer end flag rides along with the samples
  always_ff @(posedge clk_i) begin
    if (adv.ld_s1) begin
      be_s1_q <= buffer_end_i;
    end
    if (adv.ld_out) begin
      be_out_q <= be_s1_q;
    end
  end

  pcmcv_side #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_left (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .raw_i      (first_sample_i),
    .float_fmt_i(float_fmt),
    .gain_i     (gain),
    .pcm_o      (left_pcm_o)
  );

  pcmcv_side #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_right (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .raw_i      (right_raw),
    .float_fmt_i(float_fmt),
    .gain_i     (gain),
    .pcm_o      (right_pcm_o)
  );

  assign out_valid_o      = out_vld_q;
  assign buffer_end_out_o = be_out_q;

endmodule
`default_nettype wire

// ===== rtl/pcmcv_gain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcmcv_gain
// configuration registers and the registered combined gain
// ----------------------------------------------------------------------------
module pcmcv_gain
  import pcmcv_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 15,
  localparam int GAIN_W = GAIN_FRAC_BITS + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic      [FMT_W-1:0]      format_o,
  output logic      [GAIN_W-1:0]     gain_o
);

  localparam int PV_W  = GAIN_FRAC_BITS + 1;
  localparam int MG_W  = GAIN_FRAC_BITS + 2;
  localparam int CMP_W = (MG_W > MGAIN_W) ? MG_W : MGAIN_W;
  localparam int PR_W  = PV_W + MG_W;

  localparam logic [CMP_W-1:0] UNITY  = CMP_W'(1) << GAIN_FRAC_BITS;
  localparam logic [CMP_W-1:0] TWO_UN = UNITY << 1;

  // reset value of the combined gain, worked out at elaboration
  localparam longint unsigned UNITY_L = 64'd1 << GAIN_FRAC_BITS;
  localparam longint unsigned RST_PV  =
    (64'(VOL_RST) > UNITY_L) ? UNITY_L : 64'(VOL_RST);
  localparam longint unsigned RST_MG  =
    (64'(MGAIN_RST) > (UNITY_L << 1)) ? (UNITY_L << 1) : 64'(MGAIN_RST);
  localparam longint unsigned RST_G   = (RST_PV * RST_MG) >> GAIN_FRAC_BITS;

  logic [FMT_W-1:0]   format_q, format_d;
  logic [VOL_W-1:0]   vol_q, vol_d;
  logic [MGAIN_W-1:0] mgain_q, mgain_d;
  logic [GAIN_W-1:0]  gain_q, gain_d;

  logic [CMP_W-1:0] vol_ext, mg_ext, pv_c, mg_c;
  logic [PR_W-1:0]  prod;

  always_comb begin
    format_d = format_q;
    vol_d    = vol_q;
    mgain_d  = mgain_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORMAT:      format_d = cfg_wdata_i[FMT_W-1:0];
        REG_PORT_VOL:    vol_d    = cfg_wdata_i[VOL_W-1:0];
        REG_MASTER_GAIN: mgain_d  = cfg_wdata_i[MGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_RST;
      vol_q    <= VOL_RST;
      mgain_q  <= MGAIN_RST;
    end else begin
      format_q <= format_d;
      vol_q    <= vol_d;
      mgain_q  <= mgain_d;
    end
  end

  // clamp volume to unity and master gain to two, then one product
  // taken from the next register values so the gain changes with the write
  always_comb begin
    vol_ext = CMP_W'(vol_d);
    mg_ext  = CMP_W'(mgain_d);
    pv_c    = (vol_ext > UNITY) ? UNITY : vol_ext;
    mg_c    = (mg_ext > TWO_UN) ? TWO_UN : mg_ext;
    prod    = PR_W'(pv_c[PV_W-1:0]) * PR_W'(mg_c[MG_W-1:0]);
    gain_d  = prod[GAIN_FRAC_BITS +: GAIN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(RST_G);
    end else begin
      gain_q <= gain_d;
    end
  end

  assign format_o = format_q;
  assign gain_o   = gain_q;

endmodule
`default_nettype wire

// ===== rtl/pcmcv_side.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcmcv_side
// one output side: decode, gain product, saturate and scale to s16
// ----------------------------------------------------------------------------
module pcmcv_side
  import pcmcv_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 15,
  localparam int GAIN_W = GAIN_FRAC_BITS + 2
) (
  input  wire logic                clk_i,
  input  wire pcmcv_adv_t          adv_i,
  input  wire logic [SAMPLE_W-1:0] raw_i,
  input  wire logic                float_fmt_i,
  input  wire logic [GAIN_W-1:0]   gain_i,
  output logic signed [PCM_W-1:0]  pcm_o
);

  localparam int OP_W = 24;
  localparam int P_W  = OP_W + GAIN_W;
  localparam int SC_W = P_W + MAG_W;
  localparam int R_W  = 10;

  localparam logic signed [R_W-1:0] R_S16  = R_W'(S16_FRAC_BITS + GAIN_FRAC_BITS);
  localparam logic signed [R_W-1:0] R_F32  = R_W'(F32_SHIFT_BASE + GAIN_FRAC_BITS);
  localparam logic signed [R_W-1:0] R_CAP  = R_W'(SHIFT_MAX);

  // decode stage
  logic [15:0]            s16_v;
  logic [16:0]            s16_mag;
  logic [7:0]             exp_v, exp_eff;
  logic [22:0]            man_v;
  logic signed [R_W-1:0]  r_full;
  logic [OP_W-1:0]        op_s;
  logic                   neg_s, nan_s, sat_s;
  logic [SHIFT_W-1:0]     r_s;
  logic [P_W-1:0]         prod_s;

  always_comb begin
    s16_v   = raw_i[15:0];
    s16_mag = s16_v[15] ? (17'h10000 - {1'b0, s16_v}) : {1'b0, s16_v};
    exp_v   = raw_i[30:23];
    man_v   = raw_i[22:0];
    exp_eff = (exp_v == 8'd0) ? 8'd1 : exp_v;
    if (float_fmt_i) begin
      // hidden bit is set for infinity too, so its product is zero only at zero gain
      op_s   = {exp_v != 8'd0, man_v};
      neg_s  = raw_i[31];
      nan_s  = (exp_v == F32_EXP_SPECIAL) && (man_v != 23'd0);
      r_full = R_F32 - $signed({2'b00, exp_eff});
      sat_s  = (exp_v == F32_EXP_SPECIAL) || (r_full <= 0);
    end else begin
      op_s   = {7'd0, s16_mag};
      neg_s  = s16_v[15];
      nan_s  = 1'b0;
      r_full = R_S16;
      sat_s  = 1'b0;
    end
    r_s    = (r_full >= R_CAP) ? SHIFT_W'(SHIFT_MAX) : r_full[SHIFT_W-1:0];
    prod_s = P_W'(op_s) * P_W'(gain_i);
  end

  // product stage
  logic [P_W-1:0]     p_q;
  logic [SHIFT_W-1:0] r_q;
  logic               neg_q, nan_q, sat_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_s1) begin
      p_q   <= prod_s;
      r_q   <= r_s;
      neg_q <= neg_s;
      nan_q <= nan_s;
      sat_q <= sat_s;
    end
  end

  // scale stage: p * 32767 >> r, full scale once p >> r reaches one or sat_q, zero on nan
  logic [SC_W-1:0]        scaled;
  logic                   over;
  logic [MAG_W-1:0]       mag;
  logic [PCM_W-1:0]       pcm_d;
  logic signed [PCM_W-1:0] pcm_q;

  always_comb begin
    scaled = ({p_q, MAG_W'(0)} - SC_W'(p_q)) >> r_q;
    over   = (p_q >> r_q) != '0;
    if (nan_q || (p_q == '0)) begin
      mag = '0;
    end else if (sat_q || over) begin
      mag = PCM_FULL_SCALE;
    end else begin
      mag = scaled[MAG_W-1:0];
    end
    pcm_d = neg_q ? (PCM_W'(0) - {1'b0, mag}) : {1'b0, mag};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_out) begin
      pcm_q <= pcm_d;
    end
  end

  assign pcm_o = pcm_q;

endmodule
`default_nettype wire

// ===== rtl/pcmcv_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcmcv_chk
// port level checks for the converter, bound to the top level
// ----------------------------------------------------------------------------
module pcmcv_chk
  import pcmcv_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_i,
  input wire logic                    buffer_end_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_stall_i,
  input wire logic signed [PCM_W-1:0] left_pcm_i,
  input wire logic signed [PCM_W-1:0] right_pcm_i,
  input wire logic                    buffer_end_out_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_i;

  // a held output word keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(left_pcm_i)
      && $stable(right_pcm_i) && $stable(buffer_end_out_i))
    else $error("output word changed while stalled");

  // input only backs up when the output is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled with output free");

  // an accepted word is followed by a valid output past the product register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 out_valid_i)
    else $error("accepted word did not reach the output");

  // with the output free the flag passes be_s1_q and be_out_q to the output
  a_flag_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 (!out_valid_i || !out_stall_i) |=>
      out_valid_i && (buffer_end_out_i == $past(buffer_end_i, 2)))
    else $error("buffer end flag lost or reordered");

endmodule

bind pcm_frame_to_stereo_s16_gain_unit pcmcv_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .buffer_end_i    (buffer_end_i),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .left_pcm_i      (left_pcm_o),
  .right_pcm_i     (right_pcm_o),
  .buffer_end_out_i(buffer_end_out_o)
);
`default_nettype wire

// ===== verif/pcm_stereo_gain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_stereo_gain_checker
// watches the config port and both word channels of the stereo gain unit,
// predicts every output word and compares it field by field in order
// ----------------------------------------------------------------------------
module pcm_stereo_gain_checker
  import pcmcv_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [SAMPLE_W-1:0]   first_sample_i,
  input  wire logic [SAMPLE_W-1:0]   second_sample_i,
  input  wire logic                  buffer_end_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [PCM_W-1:0]      left_pcm_i,
  input  wire logic [PCM_W-1:0]      right_pcm_i,
  input  wire logic                  buffer_end_out_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam logic [63:0] UNITY = 64'd1 << GAIN_FRAC_BITS;
  localparam int          DUE_DEPTH = 16;

  typedef struct packed {
    logic [PCM_W-1:0] left;
    logic [PCM_W-1:0] right;
    logic             last;
  } stereo_word_t;

  logic [FMT_W-1:0]   fmt_q;
  logic [VOL_W-1:0]   vol_q;
  logic [MGAIN_W-1:0] mgain_q;
  logic [63:0]        gain_q;
  stereo_word_t       due_mem [DUE_DEPTH];
  int                 due_wr = 0;
  int                 due_rd = 0;
  int                 mismatches = 0;
  int                 due_n = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_n;

  // port volume clamped to unity, master gain to two, product truncated
  function automatic logic [63:0] combined_gain(input logic [VOL_W-1:0] vol,
                                                input logic [MGAIN_W-1:0] mgain);
    logic [63:0] v;
    logic [63:0] m;
    v = (64'(vol) > UNITY) ? UNITY : 64'(vol);
    m = (64'(mgain) > 2 * UNITY) ? 2 * UNITY : 64'(mgain);
    return (v * m) >> GAIN_FRAC_BITS;
  endfunction

  // magnitude of min(p * 2^sh, 1) * full scale, truncated
  function automatic logic [63:0] full_scale_mag(input logic [63:0] p, input int sh);
    int r;
    r = -sh;
    if (p == 0) return 64'd0;
    if (sh >= 0) return 64'(PCM_FULL_SCALE);
    if (r >= 60) return 64'd0;
    if ((p >> r) != 0) return 64'(PCM_FULL_SCALE);
    return (p * 64'(PCM_FULL_SCALE)) >> r;
  endfunction

  function automatic logic [PCM_W-1:0] side_pcm(input logic [SAMPLE_W-1:0] raw,
                                               input logic flt,
                                               input logic [63:0] gain);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] man;
    int          ex;
    if (!flt) begin
      neg = raw[15];
      mag = neg ? (64'h10000 - 64'(raw[15:0])) : 64'(raw[15:0]);
      mag = full_scale_mag(mag * gain, -(S16_FRAC_BITS + GAIN_FRAC_BITS));
    end else begin
      neg = raw[31];
      ex  = int'(raw[30:23]);
      man = 64'(raw[22:0]);
      if (raw[30:23] == F32_EXP_SPECIAL) begin
        // nan gives silence, infinity saturates unless the gain is zero
        if (man != 0) return '0;
        mag = (gain != 0) ? 64'(PCM_FULL_SCALE) : 64'd0;
      end else begin
        if (ex == 0) ex = 1;
        else man = man | 64'h80_0000;
        mag = full_scale_mag(man * gain, ex - F32_SHIFT_BASE - GAIN_FRAC_BITS);
      end
    end
    return neg ? (PCM_W'(0) - mag[PCM_W-1:0]) : mag[PCM_W-1:0];
  endfunction

  function automatic stereo_word_t predict_word(input logic [SAMPLE_W-1:0] s0,
                                                input logic [SAMPLE_W-1:0] s1,
                                                input logic last);
    stereo_word_t w;
    logic         mono;
    logic         flt;
    case (fmt_q)
      FMT_S16_MONO, FMT_F32_MONO: mono = 1'b1;
      default:                    mono = 1'b0;
    endcase
    case (fmt_q)
      FMT_F32_MONO, FMT_F32_STEREO, FMT_F32_8CH, FMT_F32_8CH_ALT: flt = 1'b1;
      default:                                                    flt = 1'b0;
    endcase
    w.left  = side_pcm(s0, flt, gain_q);
    w.right = mono ? w.left : side_pcm(s1, flt, gain_q);
    w.last  = last;
    return w;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_word_t want;
    if (!rst_ni) begin
      fmt_q   = FMT_RST;
      vol_q   = VOL_RST;
      mgain_q = MGAIN_RST;
      gain_q  = combined_gain(VOL_RST, MGAIN_RST);
      due_wr  = 0;
      due_rd  = 0;
      due_n  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_wr == due_rd) begin
          note_mismatch("word with none due, left", $signed(left_pcm_i), 0);
        end else begin
          want = due_mem[due_rd % DUE_DEPTH];
          due_rd++;
          if (left_pcm_i !== want.left)
            note_mismatch("left_pcm", $signed(left_pcm_i), $signed(want.left));
          if (right_pcm_i !== want.right)
            note_mismatch("right_pcm", $signed(right_pcm_i), $signed(want.right));
          if (buffer_end_out_i !== want.last)
            note_mismatch("buffer_end_out", buffer_end_out_i, want.last);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_mem[due_wr % DUE_DEPTH] =
          predict_word(first_sample_i, second_sample_i, buffer_end_i);
        due_wr++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FORMAT:      fmt_q   = cfg_wdata_i[FMT_W-1:0];
          REG_PORT_VOL:    vol_q   = cfg_wdata_i[VOL_W-1:0];
          REG_MASTER_GAIN: mgain_q = cfg_wdata_i[MGAIN_W-1:0];
          default:         ;
        endcase
        gain_q = combined_gain(vol_q, mgain_q);
      end
      due_n <= due_wr - due_rd;
    end
  end

endmodule

// ===== verif/pcm_frame_to_stereo_s16_gain_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_to_stereo_s16_gain_unit_test
// drives frames through the stereo gain unit under many format and gain
// settings with random gaps and output stalls; the checker predicts each word
// ----------------------------------------------------------------------------
module pcm_frame_to_stereo_s16_gain_unit_test;
  import pcmcv_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASES         = 16;
  localparam int WORDS_PER_PHASE = 125;

  // index 3 is not a register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // float32 bit patterns for the directed frames
  localparam logic [31:0] F32_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F32_HALF     = 32'h3F00_0000;
  localparam logic [31:0] F32_JUST_ONE = 32'h3F7F_FFFF;
  localparam logic [31:0] F32_MAX      = 32'h7F7F_FFFF;
  localparam logic [31:0] F32_INF      = 32'h7F80_0000;
  localparam logic [31:0] F32_NAN      = 32'h7FC0_0000;
  localparam logic [31:0] F32_SIGN     = 32'h8000_0000;
  localparam logic [31:0] F32_MIN_NORM = 32'h0080_0000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   first_sample = '0;
  logic [SAMPLE_W-1:0]   second_sample = '0;
  logic                  buffer_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [PCM_W-1:0] left_pcm;
  logic signed [PCM_W-1:0] right_pcm;
  logic                  buffer_end_out;

  int   errors;
  int   words_due;
  int   cycles = 0;
  logic tx_burst = 1'b0;   // sender runs with no gaps while set
  logic rx_burst = 1'b0;   // receiver never stalls while set
  logic [FMT_W-1:0] cur_fmt = FMT_RST;

  always #10 clk = ~clk;

  pcm_frame_to_stereo_s16_gain_unit #(.GAIN_FRAC_BITS(15)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .first_sample_i   (first_sample),
    .second_sample_i  (second_sample),
    .buffer_end_i     (buffer_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .left_pcm_o       (left_pcm),
    .right_pcm_o      (right_pcm),
    .buffer_end_out_o (buffer_end_out)
  );

  pcm_stereo_gain_checker #(.GAIN_FRAC_BITS(15)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .first_sample_i   (first_sample),
    .second_sample_i  (second_sample),
    .buffer_end_i     (buffer_end),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .left_pcm_i       (left_pcm),
    .right_pcm_i      (right_pcm),
    .buffer_end_out_i (buffer_end_out),
    .fail_count_o     (errors),
    .pending_o        (words_due)
  );

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one register write; we drops on the next edge so back to back writes
  // never lower and raise it in the same step
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [FMT_W-1:0] fmt, input logic [CFG_DATA_W-1:0] vol,
                            input logic [CFG_DATA_W-1:0] mgain);
    cfg_write(REG_FORMAT, CFG_DATA_W'(fmt));
    cfg_write(REG_PORT_VOL, vol);
    cfg_write(REG_MASTER_GAIN, mgain);
    cur_fmt = fmt;
    // idle before the next frames
    repeat (2) @(posedge clk);
  endtask

  // offer one frame after a random gap, return at the edge that takes it
  task automatic send_frame(input logic [31:0] s0, input logic [31:0] s1, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    first_sample  <= s0;
    second_sample <= s1;
    buffer_end    <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every predicted word has come out, then idle with the input low
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sample words biased toward the interesting part of the range
  function automatic logic [31:0] pick_sample(input logic flt);
    logic [31:0] w;
    int          sel;
    w   = $urandom;
    sel = $urandom_range(0, 9);
    if (!flt) begin
      case (sel)
        0: w[15:0] = 16'h7FFF;
        1: w[15:0] = 16'h8000;
        2: w[15:0] = 16'($urandom_range(0, 15));
        3: w[15:0] = 16'hFFFF - 16'($urandom_range(0, 15));
        default: ;
      endcase
    end else begin
      case (sel)
        0:       w[30:23] = F32_EXP_SPECIAL;
        1:       w[30:23] = 8'h00;
        2, 3, 4, 5, 6: w[30:23] = 8'($urandom_range(105, 128));
        default: ;
      endcase
    end
    return w;
  endfunction

  // receiver: random stall before each word, with no-stall stretches
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] vol;
    logic [CFG_DATA_W-1:0] mgain;
    logic                  flt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stereo s16 at unity, full scale and garbage upper halves
    send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0);
    send_frame(32'h0000_FFFF, 32'h0000_0000, 1'b1);
    send_frame(32'hABCD_8000, 32'h1234_7FFF, 1'b0);
    send_frame(32'h0000_0001, 32'hFFFF_FFFE, 1'b1);
    drain();

    // float stereo at unity: signs, zeros, infinities, nan, denormal, max
    set_config(FMT_F32_STEREO, CFG_DATA_W'(32768), CFG_DATA_W'(32768));
    send_frame(F32_ONE, F32_ONE | F32_SIGN, 1'b0);
    send_frame(32'h0000_0000, F32_SIGN, 1'b1);
    send_frame(F32_INF, F32_INF | F32_SIGN, 1'b0);
    send_frame(F32_NAN, 32'h0000_0001, 1'b1);
    send_frame(F32_MAX, F32_HALF, 1'b0);
    send_frame(F32_MIN_NORM | F32_SIGN, F32_JUST_ONE, 1'b1);
    drain();

    // mono formats copy the first sample, second one ignored
    set_config(FMT_F32_MONO, CFG_DATA_W'(32768), CFG_DATA_W'(32768));
    send_frame(F32_HALF | F32_SIGN, F32_NAN, 1'b0);
    drain();
    set_config(FMT_S16_MONO, CFG_DATA_W'(32768), CFG_DATA_W'(32768));
    send_frame(32'h0000_8000, 32'h0000_7FFF, 1'b1);
    drain();

    // zero volume kills even infinity
    set_config(FMT_F32_8CH, CFG_DATA_W'(0), CFG_DATA_W'(65536));
    send_frame(F32_INF, F32_ONE, 1'b0);
    drain();

    // volume above unity and master above two both clamp; spare index ignored
    set_config(FMT_S16_8CH, CFG_DATA_W'(17'h1FFFF), CFG_DATA_W'(17'h1FFFF));
    cfg_write(REG_SPARE, CFG_DATA_W'(0));
    repeat (2) @(posedge clk);
    send_frame(32'h0000_4000, 32'h0000_C000, 1'b0);
    send_frame(32'h0000_0001, 32'h0000_3FFF, 1'b1);
    drain();

    // random phases, every format twice, gains drawn with extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       vol = CFG_DATA_W'(0);
        1:       vol = CFG_DATA_W'(32768);
        2:       vol = CFG_DATA_W'($urandom);
        default: vol = CFG_DATA_W'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 5))
        0:       mgain = CFG_DATA_W'(0);
        1:       mgain = CFG_DATA_W'(65536);
        2:       mgain = CFG_DATA_W'(17'h1FFFF);
        3:       mgain = CFG_DATA_W'(32768);
        default: mgain = CFG_DATA_W'($urandom_range(0, 65536));
      endcase
      set_config(FMT_W'(ph % 8), vol, mgain);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
        repeat (2) @(posedge clk);
      end
      flt = fmt_float32(cur_fmt);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
        send_frame(pick_sample(flt), pick_sample(flt), 1'($urandom));
      end
      // sender waits out every result before the next setting
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
